/* rtl/vpd_pkg.sv */
// ----------------------------------------------------------------------------
// vpd_pkg: VP8 payload descriptor parser package
// Transaction types, parse phases and parser state shared by the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package vpd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_EXT   = 3'd1,
    PH_PIC1  = 3'd2,
    PH_PIC2  = 3'd3,
    PH_TL0   = 3'd4,
    PH_TK    = 3'd5,
    PH_PAY   = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_packet;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  descriptor_length;
    logic        extension_present;
    logic        non_reference;
    logic        partition_start;
    logic [2:0]  partition_index;
    logic [3:0]  present_flags;
    logic [15:0] picture_id;
    logic [7:0]  tl0_index;
    logic [1:0]  temporal_layer;
    logic        y_sync;
    logic [4:0]  key_index;
  } out_t;

  // Descriptor flags gathered from the mandatory and extension octets
  typedef struct packed {
    logic       flag_i;
    logic       flag_l;
    logic       flag_t;
    logic       flag_k;
    logic       flag_x;
    logic       flag_n;
    logic       flag_s;
    logic [2:0] pid;
  } flags_t;

  typedef struct packed {
    phase_e      phase;
    logic        skip_rest;
    logic [2:0]  octets_seen;
    flags_t      flags;
    logic [15:0] pic_acc;
    logic [7:0]  tl0_acc;
    logic [7:0]  lk_acc;
  } state_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

endpackage

`default_nettype wire

/* rtl/vpd_step.sv */
// ----------------------------------------------------------------------------
// vpd_step: per-byte parse step
// Next parser state and optional result for one accepted payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vpd_step (
  input  var vpd_pkg::state_t st_i,
  input  var vpd_pkg::in_t    in_i,
  output vpd_pkg::state_t     st_o,
  output logic                res_valid_o,
  output vpd_pkg::out_t       res_o
);

  logic [7:0]      b;
  logic            tk_any;
  vpd_pkg::phase_e after_tl0;
  vpd_pkg::phase_e after_pic;
  vpd_pkg::out_t   ok_res;
  vpd_pkg::out_t   bad_res;

  assign b = in_i.payload_byte;

  always_comb begin
    bad_res        = '0;
    bad_res.status = vpd_pkg::STATUS_INVALID;

    ok_res                   = '0;
    ok_res.status            = vpd_pkg::STATUS_OK;
    ok_res.descriptor_length = st_i.octets_seen;
    ok_res.extension_present = st_i.flags.flag_x;
    ok_res.non_reference     = st_i.flags.flag_n;
    ok_res.partition_start   = st_i.flags.flag_s;
    ok_res.partition_index   = st_i.flags.pid;
    ok_res.present_flags     = {st_i.flags.flag_i, st_i.flags.flag_l,
                                st_i.flags.flag_t, st_i.flags.flag_k};
    ok_res.picture_id        = st_i.pic_acc;
    ok_res.tl0_index         = st_i.tl0_acc;
    ok_res.temporal_layer    = st_i.flags.flag_t ? st_i.lk_acc[7:6] : 2'd0;
    ok_res.y_sync            = st_i.flags.flag_t & st_i.lk_acc[5];
    ok_res.key_index         = st_i.flags.flag_k ? st_i.lk_acc[4:0] : 5'd0;
  end

  // Phase successors, from the flags held in state (extension octet uses its own)
  always_comb begin
    tk_any    = st_i.flags.flag_t | st_i.flags.flag_k;
    after_tl0 = tk_any ? vpd_pkg::PH_TK : vpd_pkg::PH_PAY;
    after_pic = st_i.flags.flag_l ? vpd_pkg::PH_TL0 : after_tl0;
  end

  always_comb begin
    st_o        = st_i;
    res_valid_o = 1'b0;
    res_o       = bad_res;

    if (!st_i.skip_rest) begin
      unique case (st_i.phase)
        vpd_pkg::PH_EXT: begin
          st_o.flags.flag_i = b[7];
          st_o.flags.flag_l = b[6];
          st_o.flags.flag_t = b[5];
          st_o.flags.flag_k = b[4];
          st_o.octets_seen  = 3'd2;
          if (b[6] && !b[5]) begin
            res_valid_o    = 1'b1;
            st_o.skip_rest = 1'b1;
          end else if (b[7]) begin
            st_o.phase = vpd_pkg::PH_PIC1;
          end else if (b[6]) begin
            st_o.phase = vpd_pkg::PH_TL0;
          end else if (b[5] || b[4]) begin
            st_o.phase = vpd_pkg::PH_TK;
          end else begin
            st_o.phase = vpd_pkg::PH_PAY;
          end
        end
        vpd_pkg::PH_PIC1: begin
          st_o.octets_seen = st_i.octets_seen + 3'd1;
          if (b[7]) begin
            st_o.pic_acc = {b, 8'h00};
            st_o.phase   = vpd_pkg::PH_PIC2;
          end else begin
            st_o.pic_acc = {8'h00, b};
            st_o.phase   = after_pic;
          end
        end
        vpd_pkg::PH_PIC2: begin
          st_o.octets_seen = st_i.octets_seen + 3'd1;
          st_o.pic_acc     = st_i.pic_acc | {8'h00, b};
          st_o.phase       = after_pic;
        end
        vpd_pkg::PH_TL0: begin
          st_o.octets_seen = st_i.octets_seen + 3'd1;
          st_o.tl0_acc     = b;
          st_o.phase       = after_tl0;
        end
        vpd_pkg::PH_TK: begin
          st_o.octets_seen = st_i.octets_seen + 3'd1;
          st_o.lk_acc      = b;
          st_o.phase       = vpd_pkg::PH_PAY;
        end
        vpd_pkg::PH_PAY: begin
          res_valid_o    = 1'b1;
          res_o          = ok_res;
          st_o.skip_rest = 1'b1;
        end
        default: begin
          // mandatory octet; the unused phase code lands here as well
          st_o.pic_acc     = '0;
          st_o.tl0_acc     = '0;
          st_o.lk_acc      = '0;
          st_o.flags       = '0;
          st_o.flags.pid   = b[2:0];
          st_o.flags.flag_x = b[7];
          st_o.flags.flag_n = b[5];
          st_o.flags.flag_s = b[4];
          st_o.octets_seen = 3'd1;
          st_o.phase       = b[7] ? vpd_pkg::PH_EXT : vpd_pkg::PH_PAY;
        end
      endcase

      // packet ended before any payload byte
      if (in_i.end_of_packet && !res_valid_o) begin
        res_valid_o = 1'b1;
        res_o       = bad_res;
      end
    end

    if (in_i.end_of_packet) begin
      st_o       = '0;
      st_o.phase = vpd_pkg::PH_FIRST;
    end
  end

endmodule

`default_nettype wire

/* rtl/vpd_out_buf.sv */
// ----------------------------------------------------------------------------
// vpd_out_buf: result output buffer
// Output register with a skid entry; input is held off once the skid entry is full.
// ----------------------------------------------------------------------------
`default_nettype none

module vpd_out_buf (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          push_i,
  input  var vpd_pkg::out_t push_data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  var logic          out_ready_i,
  output vpd_pkg::out_t     out_data_o
);

  logic          main_valid_q, main_valid_d;
  logic          skid_valid_q, skid_valid_d;
  vpd_pkg::out_t main_q, main_d;
  vpd_pkg::out_t skid_q, skid_d;
  logic          pop;

  assign pop         = main_valid_q && out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        main_d       = push_data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

/* rtl/vp8_payload_descriptor_parser.sv */
// ----------------------------------------------------------------------------
// vp8_payload_descriptor_parser: VP8 RTP payload descriptor parser
// One byte accepted per cycle while the output buffer has space; results are registered.
// Throughput is set by the combinational parse step and the output skid stage.
// Reset clears the parser to the mandatory-octet phase and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module vp8_payload_descriptor_parser (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          in_valid_i,
  output logic              in_ready_o,
  input  var vpd_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  var logic          out_ready_i,
  output vpd_pkg::out_t     out_data_o
);

  vpd_pkg::state_t st_q, st_d;
  logic            accept;
  logic            res_valid;
  vpd_pkg::out_t   res;
  logic            space;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  vpd_step u_step (
    .st_i        (st_q),
    .in_i        (in_data_i),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // all-zero state is the mandatory-octet phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  vpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/tb_vp8_payload_descriptor_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vp8_payload_descriptor_parser: VP8 payload descriptor parser testbench
// Streams whole RTP payloads a byte at a time: a short list of hand-built
// packets, then random packets (mostly well-formed descriptors, some cut
// short, some noise). A local model of the parser predicts one descriptor
// per packet; every result transaction is checked against the oldest
// prediction. Both sides idle in short bursts, and once the receiver stalls
// for a long stretch so that the parser backs up.
// ----------------------------------------------------------------------------

module tb_vp8_payload_descriptor_parser;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned QUIET_TAIL     = 150;
  localparam int unsigned RANDOM_BYTES   = 1700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_ready_o;
  vpd_pkg::in_t  in_data = '0;
  logic          out_valid_o;
  logic          out_ready = 1'b0;
  vpd_pkg::out_t out_data_o;

  vp8_payload_descriptor_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  vpd_pkg::in_t  pending_bytes[$];
  vpd_pkg::out_t expected_desc_q[$];

  int unsigned desc_checked = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cnt = 0;
  logic        hold_done = 1'b0;
  logic        quiet = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;

  // Parser model state
  vpd_pkg::phase_e pp_phase = vpd_pkg::PH_FIRST;
  logic            pp_skip = 1'b0;
  logic [2:0]      pp_octets = '0;
  vpd_pkg::flags_t pp_flags = '0;
  logic [15:0]     pp_pic = '0;
  logic [7:0]      pp_tl0 = '0;
  logic [7:0]      pp_lk = '0;

  function automatic vpd_pkg::phase_e phase_after(input vpd_pkg::phase_e ph);
    if (ph == vpd_pkg::PH_EXT && pp_flags.flag_i) return vpd_pkg::PH_PIC1;
    if ((ph == vpd_pkg::PH_EXT || ph == vpd_pkg::PH_PIC1 || ph == vpd_pkg::PH_PIC2) &&
        pp_flags.flag_l) return vpd_pkg::PH_TL0;
    if (ph != vpd_pkg::PH_TK && (pp_flags.flag_t || pp_flags.flag_k)) return vpd_pkg::PH_TK;
    return vpd_pkg::PH_PAY;
  endfunction

  // Advances the model by one byte; returns 1 when the byte yields a descriptor
  function automatic bit predict_descriptor(input logic [7:0] b, input logic last,
                                            output vpd_pkg::out_t desc);
    bit            got;
    vpd_pkg::out_t r;
    got = 1'b0;
    r   = '0;
    if (!pp_skip) begin
      case (pp_phase)
        vpd_pkg::PH_EXT: begin
          pp_flags.flag_i |= b[7];
          pp_flags.flag_l |= b[6];
          pp_flags.flag_t |= b[5];
          pp_flags.flag_k |= b[4];
          pp_octets = 3'd2;
          if (pp_flags.flag_l && !pp_flags.flag_t) begin
            r.status = vpd_pkg::STATUS_INVALID;
            got      = 1'b1;
            pp_skip  = 1'b1;
          end else begin
            pp_phase = phase_after(vpd_pkg::PH_EXT);
          end
        end
        vpd_pkg::PH_PIC1: begin
          pp_octets = pp_octets + 3'd1;
          if (b[7]) begin
            pp_pic   = {b, 8'h00};
            pp_phase = vpd_pkg::PH_PIC2;
          end else begin
            pp_pic   = {8'h00, b};
            pp_phase = phase_after(vpd_pkg::PH_PIC1);
          end
        end
        vpd_pkg::PH_PIC2: begin
          pp_octets = pp_octets + 3'd1;
          pp_pic    = pp_pic | {8'h00, b};
          pp_phase  = phase_after(vpd_pkg::PH_PIC2);
        end
        vpd_pkg::PH_TL0: begin
          pp_octets = pp_octets + 3'd1;
          pp_tl0    = b;
          pp_phase  = phase_after(vpd_pkg::PH_TL0);
        end
        vpd_pkg::PH_TK: begin
          pp_octets = pp_octets + 3'd1;
          pp_lk     = b;
          pp_phase  = vpd_pkg::PH_PAY;
        end
        vpd_pkg::PH_PAY: begin
          r.status            = vpd_pkg::STATUS_OK;
          r.descriptor_length = pp_octets;
          r.extension_present = pp_flags.flag_x;
          r.non_reference     = pp_flags.flag_n;
          r.partition_start   = pp_flags.flag_s;
          r.partition_index   = pp_flags.pid;
          r.present_flags     = {pp_flags.flag_i, pp_flags.flag_l,
                                 pp_flags.flag_t, pp_flags.flag_k};
          r.picture_id        = pp_pic;
          r.tl0_index         = pp_tl0;
          r.temporal_layer    = pp_flags.flag_t ? pp_lk[7:6] : 2'd0;
          r.y_sync            = pp_flags.flag_t & pp_lk[5];
          r.key_index         = pp_flags.flag_k ? pp_lk[4:0] : 5'd0;
          got     = 1'b1;
          pp_skip = 1'b1;
        end
        default: begin
          // mandatory octet; an unused phase code lands here too
          pp_pic        = '0;
          pp_tl0        = '0;
          pp_lk         = '0;
          pp_flags      = '0;
          pp_flags.pid  = b[2:0];
          pp_flags.flag_x = b[7];
          pp_flags.flag_n = b[5];
          pp_flags.flag_s = b[4];
          pp_octets     = 3'd1;
          pp_phase      = b[7] ? vpd_pkg::PH_EXT : vpd_pkg::PH_PAY;
        end
      endcase
      // packet ended before any payload byte
      if (last && !got && !pp_skip) begin
        r        = '0;
        r.status = vpd_pkg::STATUS_INVALID;
        got      = 1'b1;
      end
    end
    if (last) begin
      pp_phase  = vpd_pkg::PH_FIRST;
      pp_skip   = 1'b0;
      pp_octets = '0;
      pp_flags  = '0;
      pp_pic    = '0;
      pp_tl0    = '0;
      pp_lk     = '0;
    end
    desc = r;
    return got;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    vpd_pkg::in_t t;
    t.payload_byte  = b;
    t.end_of_packet = last;
    pending_bytes.push_back(t);
  endtask

  // Sender: offers queued bytes, predicts on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    vpd_pkg::out_t desc;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
      quiet    <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        if (predict_descriptor(in_data.payload_byte, in_data.end_of_packet, desc))
          expected_desc_q.push_back(desc);
      end
      quiet <= (pending_bytes.size() < QUIET_TAIL);
      if (!in_valid || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap   <= $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall, once, early in the random part
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && desc_checked >= 40) begin
      hold_cnt  <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Receiver: checks each result transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    vpd_pkg::out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_desc_q.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("ERROR: unexpected descriptor %h", out_data_o);
        end else begin
          want = expected_desc_q.pop_front();
          if (out_data_o !== want) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10) begin
              $display("ERROR: descriptor %0d", desc_checked);
              $display("  exp st=%0d len=%0d x=%0d n=%0d s=%0d pid=%0d fl=%h pic=%h",
                       want.status, want.descriptor_length, want.extension_present,
                       want.non_reference, want.partition_start, want.partition_index,
                       want.present_flags, want.picture_id);
              $display("      tl0=%h tid=%0d y=%0d key=%0d", want.tl0_index,
                       want.temporal_layer, want.y_sync, want.key_index);
              $display("  got st=%0d len=%0d x=%0d n=%0d s=%0d pid=%0d fl=%h pic=%h",
                       out_data_o.status, out_data_o.descriptor_length,
                       out_data_o.extension_present, out_data_o.non_reference,
                       out_data_o.partition_start, out_data_o.partition_index,
                       out_data_o.present_flags, out_data_o.picture_id);
              $display("      tl0=%h tid=%0d y=%0d key=%0d", out_data_o.tl0_index,
                       out_data_o.temporal_layer, out_data_o.y_sync,
                       out_data_o.key_index);
            end
          end
        end
        desc_checked <= desc_checked + 1;
      end
      if (hold_cnt != 0) begin
        out_ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap   <= $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("vp8_payload_descriptor_parser: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] pkt[$];
    logic [7:0] first;
    logic [7:0] ext;
    logic [7:0] pic_hi;
    int unsigned pay_len;
    int unsigned n;

    // Directed packets
    push_byte(8'h10, 1'b1);                  // ends on the mandatory octet
    push_byte(8'h00, 1'b0);                  // no extension, first payload byte
    push_byte(8'hAB, 1'b1);
    push_byte(8'hFF, 1'b0);                  // L without T
    push_byte(8'h40, 1'b0);
    push_byte(8'h55, 1'b1);
    push_byte(8'h80, 1'b0);                  // every field, 16-bit picture id
    push_byte(8'hF0, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h97, 1'b0);                  // 8-bit picture id, bytes skipped after
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);
    push_byte(8'hA8, 1'b0);                  // K only, cut before the payload
    push_byte(8'h10, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h80, 1'b0);                  // T only
    push_byte(8'h20, 1'b0);
    push_byte(8'hE5, 1'b0);
    push_byte(8'h01, 1'b1);

    // Random packets
    while (pending_bytes.size() < RANDOM_BYTES + 25) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        pkt.delete();
        first = 8'($urandom);
        first[7] = ($urandom_range(0, 3) != 0);
        pkt.push_back(first);
        if (first[7]) begin
          ext = 8'($urandom);
          if (ext[6] && !ext[5] && $urandom_range(0, 2) != 0) ext[5] = 1'b1;
          pkt.push_back(ext);
          if (ext[7]) begin
            pic_hi = 8'($urandom);
            pkt.push_back(pic_hi);
            if (pic_hi[7]) pkt.push_back(8'($urandom));
          end
          if (ext[6]) pkt.push_back(8'($urandom));
          if (ext[5] || ext[4]) pkt.push_back(8'($urandom));
        end
        pay_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
        repeat (pay_len) pkt.push_back(8'($urandom));
        if ($urandom_range(0, 7) == 0)
          n = $urandom_range(1, pkt.size());
        else
          n = pkt.size();
        for (int i = 0; i < n; i++) push_byte(pkt[i], i == n - 1);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_valid || expected_desc_q.size() != 0);
    repeat (10) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_desc_q.size() == 0)
      $display("vp8_payload_descriptor_parser: match");
    else
      $display("vp8_payload_descriptor_parser: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/vpd_pkg.sv
rtl/vpd_step.sv
rtl/vpd_out_buf.sv
rtl/vp8_payload_descriptor_parser.sv
tb/tb_vp8_payload_descriptor_parser.sv
